@@ rtl/core/lbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbc_pkg: shared definitions of the LRU block cache
// Field widths, action codes, channel words and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lbc_pkg;

  // Default sizes
  localparam int ENTRIES_DEF     = 32;
  localparam int BLOCK_BYTES_DEF = 1024;
  localparam int STAMP_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int ACTION_W = 3;
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 5;
  localparam int OFFSET_W = 10;
  localparam int BYTE_W   = 8;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_EVICT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

  // Request word
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    node_id;
    logic [KEY_W-1:0]    block_id;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] byte_index;
    logic [BYTE_W-1:0]   data_in;
  } lbc_in_t;

  // Response word
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] result_slot;
    logic [BYTE_W-1:0] data_out;
  } lbc_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic scan;
    logic access;
    logic finish;
  } lbc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_scan;
    logic is_byte;
    logic scan_done;
    logic out_free;
  } lbc_stat_t;

endpackage

@@ rtl/core/lbc_chan_if.sv @@
// ----------------------------------------------------------------------------
// lbc_chan_if: valid/ready channel
// Carries one word per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface lbc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/lbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbc_ctrl: operation sequencer
// Walks each request word through decode, entry scan or byte access (none
// for unused actions), and the final commit into the response register.
// ----------------------------------------------------------------------------
module lbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  lbc_pkg::lbc_stat_t stat,
  output lbc_pkg::lbc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_ACCESS = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Take a word only between operations
  assign req_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.is_scan) begin
          state_next = S_SCAN;
        end else if (stat.is_byte) begin
          state_next = S_ACCESS;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the response register is free
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/lbc_datapath.sv @@
// ----------------------------------------------------------------------------
// lbc_datapath: entry store, scan unit, block memory and response register
// Keys and stamps sit in memories scanned one entry per cycle; valid bits
// are flops. Block bytes sit in one byte-wide memory.
// ----------------------------------------------------------------------------
module lbc_datapath #(
  parameter int ENTRIES     = lbc_pkg::ENTRIES_DEF,
  parameter int BLOCK_BYTES = lbc_pkg::BLOCK_BYTES_DEF,
  parameter int STAMP_WIDTH = lbc_pkg::STAMP_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lbc_pkg::lbc_in_t   req_word,
  input  lbc_pkg::lbc_cmd_t  cmd,
  output lbc_pkg::lbc_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output lbc_pkg::lbc_out_t  rsp_word
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int DEPTH  = ENTRIES * BLOCK_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KEY2_W = 2 * lbc_pkg::KEY_W;

  // Captured request
  logic [lbc_pkg::ACTION_W-1:0] op_action;
  logic [lbc_pkg::KEY_W-1:0]    op_node;
  logic [lbc_pkg::KEY_W-1:0]    op_block;
  logic [lbc_pkg::SLOT_W-1:0]   op_slot;
  logic [lbc_pkg::OFFSET_W-1:0] op_off;
  logic [lbc_pkg::BYTE_W-1:0]   op_din;

  // Entry state
  logic [ENTRIES-1:0]     valid;
  logic [KEY2_W-1:0]      key_mem [ENTRIES];
  logic [STAMP_WIDTH-1:0] stamp_mem [ENTRIES];
  logic [STAMP_WIDTH-1:0] stamp_counter;
  logic [STAMP_WIDTH-1:0] stamp_next;
  logic [KEY2_W-1:0]      key_rd;
  logic [STAMP_WIDTH-1:0] stamp_rd;

  // Scan unit
  logic [CNT_W-1:0]       issue_cnt;
  logic [IDX_W-1:0]       scan_addr;
  logic                   pipe_live;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   found;
  logic [IDX_W-1:0]       best;
  logic [STAMP_WIDTH-1:0] best_stamp;
  logic                   take;
  logic                   cmp_valid;
  logic                   issue_more;

  // Byte access
  logic [lbc_pkg::BYTE_W-1:0] data_mem [DEPTH];
  logic [ADDR_W-1:0]          acc_addr;
  logic                       acc_ok;
  logic [lbc_pkg::BYTE_W-1:0] rd_byte;
  logic [IDX_W-1:0]           slot_idx;
  logic                       slot_ok;
  logic                       off_ok;

  // Response
  logic              out_valid;
  lbc_pkg::lbc_out_t out_word;
  lbc_pkg::lbc_out_t res;
  logic              key_we;
  logic              stamp_we;
  logic              is_lookup;
  logic              is_insert;
  logic              is_evict;

  assign is_lookup = (op_action == lbc_pkg::ACT_LOOKUP);
  assign is_insert = (op_action == lbc_pkg::ACT_INSERT);
  assign is_evict  = (op_action == lbc_pkg::ACT_EVICT);

  // Status toward the controller
  always_comb begin
    stat.is_scan   = op_action inside {lbc_pkg::ACT_LOOKUP, lbc_pkg::ACT_INSERT,
                                       lbc_pkg::ACT_EVICT};
    stat.is_byte   = op_action inside {lbc_pkg::ACT_WRITE, lbc_pkg::ACT_READ};
    stat.scan_done = (issue_cnt == CNT_W'(ENTRIES)) && !pipe_live;
    stat.out_free  = !out_valid || rsp_ready;
  end

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_action <= req_word.action;
      op_node   <= req_word.node_id;
      op_block  <= req_word.block_id;
      op_slot   <= req_word.slot;
      op_off    <= req_word.byte_index;
      op_din    <= req_word.data_in;
    end
  end

  // Compare the entry read last cycle
  assign cmp_valid = valid[cmp_idx];
  always_comb begin
    case (op_action)
      lbc_pkg::ACT_LOOKUP: take = !found && cmp_valid && (key_rd == {op_node, op_block});
      lbc_pkg::ACT_INSERT: take = !found && !cmp_valid;
      lbc_pkg::ACT_EVICT:  take = cmp_valid && (!found || (stamp_rd < best_stamp));
      default:             take = 1'b0;
    endcase
  end

  assign scan_addr  = issue_cnt[IDX_W-1:0];
  assign issue_more = cmd.scan && (issue_cnt != CNT_W'(ENTRIES));

  // Scan counter and running winner
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      pipe_live <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.capture) begin
      issue_cnt <= '0;
      pipe_live <= 1'b0;
      found     <= 1'b0;
    end else begin
      pipe_live <= issue_more;
      if (issue_more) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (pipe_live && take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_more) begin
      cmp_idx <= scan_addr;
    end
    if (pipe_live && take) begin
      best       <= cmp_idx;
      best_stamp <= stamp_rd;
    end
  end

  // Commit writes
  assign stamp_next = stamp_counter + 1'b1;
  assign stamp_we   = cmd.finish && found && (is_lookup || is_insert);
  assign key_we     = cmd.finish && found && is_insert;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[best] <= {op_node, op_block};
    end
    key_rd <= key_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[best] <= stamp_next;
    end
    stamp_rd <= stamp_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
      valid         <= '0;
    end else if (cmd.finish && found) begin
      if (stamp_we) begin
        stamp_counter <= stamp_next;
      end
      if (is_insert) begin
        valid[best] <= 1'b1;
      end else if (is_evict) begin
        valid[best] <= 1'b0;
      end
    end
  end

  // Byte address and access check
  assign slot_idx = IDX_W'(op_slot);
  assign slot_ok  = 32'(op_slot) < 32'(ENTRIES);
  assign off_ok   = 32'(op_off) < 32'(BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      acc_ok   <= slot_ok && off_ok && valid[slot_idx];
      acc_addr <= ADDR_W'(slot_idx) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(op_off);
    end
  end

  // Block byte memory
  always_ff @(posedge clk) begin
    if (cmd.access) begin
      if (acc_ok && (op_action == lbc_pkg::ACT_WRITE)) begin
        data_mem[acc_addr] <= op_din;
      end
      rd_byte <= data_mem[acc_addr];
    end
  end

  // Result of the finished operation
  always_comb begin
    res = '0;
    case (op_action)
      lbc_pkg::ACT_LOOKUP, lbc_pkg::ACT_INSERT, lbc_pkg::ACT_EVICT: begin
        if (found) begin
          res.ok          = 1'b1;
          res.result_slot = lbc_pkg::SLOT_W'(best);
        end
      end
      lbc_pkg::ACT_WRITE: begin
        res.ok          = acc_ok;
        res.result_slot = op_slot;
      end
      lbc_pkg::ACT_READ: begin
        res.ok          = acc_ok;
        res.result_slot = op_slot;
        res.data_out    = acc_ok ? rd_byte : '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word <= res;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp_word  = out_word;

  // Commit never overwrites a word still waiting
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || rsp_ready))
    else $error("commit while response register is held");

  // Compare stage only follows an issued entry read
  a_pipe_issued: assert property (@(posedge clk) disable iff (rst)
    pipe_live |-> $past(cmd.scan))
    else $error("compare without a scan read");

  // A successful insert advances the stamp counter by one
  a_insert_stamp: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && found && is_insert) |=>
      (stamp_counter == STAMP_WIDTH'($past(stamp_counter) + 1'b1)))
    else $error("insert did not advance stamp");

endmodule

@@ rtl/core/lru_block_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_block_cache_unit: fully associative LRU block cache
// Top level: joins the sequencer and the datapath to the two channels.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation word (action, keys, slot, byte offset, data);
//   rsp returns exactly one word (ok, result slot, data byte) per request.
//   Both are valid/ready channels; a word moves when valid and ready are high.
// Timing:
//   One request is worked at a time. Lookup, insert and evict scan every
//   entry through the key and stamp memories, one entry per cycle,
//   before the commit. Byte write and read pass through the address
//   multiply and the registered block memory read; unused actions go
//   from decode straight to the commit. The response appears in the
//   cycle after the commit.
// Reset and stall:
//   Reset frees every entry and zeroes the stamp counter; block bytes are
//   not cleared and are only valid once written. The response sits in an
//   output register: a new request is accepted while it waits, and only the
//   commit of that next request holds until the receiver takes the word.
// ----------------------------------------------------------------------------
module lru_block_cache_unit #(
  parameter int ENTRIES     = lbc_pkg::ENTRIES_DEF,
  parameter int BLOCK_BYTES = lbc_pkg::BLOCK_BYTES_DEF,
  parameter int STAMP_WIDTH = lbc_pkg::STAMP_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  lbc_chan_if.sink   req,
  lbc_chan_if.source rsp
);

  lbc_pkg::lbc_cmd_t  cmd;
  lbc_pkg::lbc_stat_t stat;
  lbc_pkg::lbc_out_t  rsp_word;
  logic               req_ready;
  logic               rsp_valid;

  lbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lbc_datapath #(
    .ENTRIES     (ENTRIES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_word  (req.payload),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .rsp_word  (rsp_word)
  );

  assign req.ready   = req_ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_word;

endmodule

@@ tb/lru_block_cache_unit_checker.sv @@
// ----------------------------------------------------------------------------
// lru_block_cache_unit_checker: response predictor and scoreboard
// Watches both channels of the LRU block cache. At each accepted request
// word it works out the response from its own copy of the entries, stamps
// and block bytes, and queues it. Each accepted response word is checked
// field by field against the oldest queued response.
// ----------------------------------------------------------------------------
module lru_block_cache_unit_checker
  import lbc_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  lbc_in_t            req_word,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  lbc_out_t           rsp_word,
  output logic [ENTRIES-1:0] live_mask,
  output int unsigned        outstanding,
  output int unsigned        mismatches,
  output int unsigned        compared
);

  // Shadow of the cache contents
  logic [ENTRIES-1:0]     line_live;
  logic [KEY_W-1:0]       line_node  [ENTRIES];
  logic [KEY_W-1:0]       line_block [ENTRIES];
  logic [STAMP_WIDTH-1:0] line_stamp [ENTRIES];
  logic [STAMP_WIDTH-1:0] stamp_now;
  logic [BYTE_W-1:0]      block_mem  [ENTRIES*BLOCK_BYTES];

  lbc_out_t    due_responses[$];
  int unsigned err_n;
  int unsigned cmp_n;

  // Free every entry and restart the stamp counter
  function automatic void clear_cache();
    line_live = '0;
    stamp_now = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      line_node[i]  = '0;
      line_block[i] = '0;
      line_stamp[i] = '0;
    end
  endfunction

  // Apply one request to the shadow and return the response it earns
  function automatic lbc_out_t resolve_request(input lbc_in_t w);
    lbc_out_t r;
    bit       found;
    int       best;
    int       addr;
    r     = '0;
    found = 1'b0;
    best  = 0;
    case (w.action)
      ACT_LOOKUP: begin
        // lowest-indexed valid match wins; restamp it
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && line_live[i] && line_node[i] == w.node_id &&
              line_block[i] == w.block_id) begin
            found         = 1'b1;
            stamp_now     = stamp_now + 1'b1;
            line_stamp[i] = stamp_now;
            r.ok          = 1'b1;
            r.result_slot = SLOT_W'(i);
          end
        end
      end
      ACT_INSERT: begin
        // fill the lowest free entry, fail when full
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && !line_live[i]) begin
            found         = 1'b1;
            line_live[i]  = 1'b1;
            stamp_now     = stamp_now + 1'b1;
            line_stamp[i] = stamp_now;
            line_node[i]  = w.node_id;
            line_block[i] = w.block_id;
            r.ok          = 1'b1;
            r.result_slot = SLOT_W'(i);
          end
        end
      end
      ACT_EVICT: begin
        // oldest stamp goes, lowest index on ties
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_live[i] && (!found || line_stamp[i] < line_stamp[best])) begin
            found = 1'b1;
            best  = i;
          end
        end
        if (found) begin
          line_live[best]  = 1'b0;
          line_node[best]  = '0;
          line_block[best] = '0;
          for (int b = 0; b < BLOCK_BYTES; b++) block_mem[best*BLOCK_BYTES + b] = '0;
          r.ok          = 1'b1;
          r.result_slot = SLOT_W'(best);
        end
      end
      ACT_WRITE, ACT_READ: begin
        r.result_slot = w.slot;
        if (int'(w.slot) < ENTRIES && int'(w.byte_index) < BLOCK_BYTES &&
            line_live[w.slot]) begin
          addr = int'(w.slot) * BLOCK_BYTES + int'(w.byte_index);
          if (w.action == ACT_WRITE) block_mem[addr] = w.data_in;
          else r.data_out = block_mem[addr];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Check responses first, then queue the prediction for a new request
  always @(posedge clk) begin
    lbc_out_t due;
    if (rst) begin
      clear_cache();
      due_responses.delete();
      err_n = 0;
      cmp_n = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_responses.size() == 0) begin
          $error("response word with nothing pending: ok=%0d result_slot=%0d data_out=%0h",
                 rsp_word.ok, rsp_word.result_slot, rsp_word.data_out);
          err_n++;
        end else begin
          due = due_responses.pop_front();
          cmp_n++;
          if (rsp_word.ok !== due.ok) begin
            $error("ok: expected %0d, got %0d", due.ok, rsp_word.ok);
            err_n++;
          end
          if (rsp_word.result_slot !== due.result_slot) begin
            $error("result_slot: expected %0d, got %0d", due.result_slot,
                   rsp_word.result_slot);
            err_n++;
          end
          if (rsp_word.data_out !== due.data_out) begin
            $error("data_out: expected %0h, got %0h", due.data_out, rsp_word.data_out);
            err_n++;
          end
        end
      end
      if (req_valid && req_ready) due_responses.push_back(resolve_request(req_word));
    end
    live_mask   <= line_live;
    outstanding <= due_responses.size();
    mismatches  <= err_n;
    compared    <= cmp_n;
  end

endmodule

@@ tb/lru_block_cache_unit_test.sv @@
// ----------------------------------------------------------------------------
// lru_block_cache_unit_test: testbench top of the LRU block cache
// Drives request words (a directed opening, then random traffic that fills
// and drains the cache through a small key pool) under four pacing phases
// of sender gaps and receiver stalls. The checker beside the block predicts
// and compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module lru_block_cache_unit_test;
  import lbc_pkg::*;

  localparam int ENTRIES    = ENTRIES_DEF;
  localparam int POOL       = 40;
  localparam int PHASE_ITEMS = 475;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic [KEY_W-1:0]    KEY_ONES     = {KEY_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbc_chan_if #(.payload_t(lbc_in_t))  req ();
  lbc_chan_if #(.payload_t(lbc_out_t)) rsp ();

  logic [ENTRIES-1:0] live_mask;
  int unsigned        outstanding;
  int unsigned        mismatches;
  int unsigned        compared;

  int unsigned        idle_pct  = 0;
  int unsigned        stall_pct = 0;
  int unsigned        tally [8];
  bit                 fill_mode = 1'b1;
  logic [KEY_W-1:0]   pool_node  [POOL];
  logic [KEY_W-1:0]   pool_block [POOL];
  logic [OFFSET_W-1:0] written_at [ENTRIES][$];

  lru_block_cache_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  lru_block_cache_unit_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_word    (req.payload),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_word    (rsp.payload),
    .live_mask   (live_mask),
    .outstanding (outstanding),
    .mismatches  (mismatches),
    .compared    (compared)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the response channel at the current rate
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Let the checker state settle, then forget bytes of freed entries
  task automatic settle();
    @(negedge clk);
    for (int s = 0; s < ENTRIES; s++) begin
      if (!live_mask[s]) written_at[s].delete();
    end
  endtask

  // Send one request word and hold it until accepted
  task automatic issue(input lbc_in_t w);
    if (w.action == ACT_WRITE && live_mask[w.slot]) written_at[w.slot].push_back(w.byte_index);
    tally[w.action]++;
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    req.valid   <= 1'b1;
    req.payload <= w;
    do @(posedge clk); while (!req.ready);
    req.valid <= 1'b0;
    settle();
  endtask

  // Hold the sender until every response has come back
  task automatic drain();
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic lbc_in_t make(input logic [ACTION_W-1:0] action,
                                   input logic [KEY_W-1:0] node, input logic [KEY_W-1:0] blk,
                                   input int slot, input int off, input int data);
    lbc_in_t w;
    w.action     = action;
    w.node_id    = node;
    w.block_id   = blk;
    w.slot       = SLOT_W'(slot);
    w.byte_index = OFFSET_W'(off);
    w.data_in    = BYTE_W'(data);
    return w;
  endfunction

  function automatic logic [ACTION_W-1:0] ACT_ACTION_SPARE();
    return ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
  endfunction

  // Build a random request aimed at the current cache contents
  function automatic lbc_in_t pick_request();
    lbc_in_t     w;
    int unsigned roll;
    int unsigned k;
    int unsigned live_q[$];
    int unsigned readable_q[$];
    int unsigned free_q[$];
    w.node_id    = {$urandom, $urandom};
    w.block_id   = {$urandom, $urandom};
    w.slot       = SLOT_W'($urandom);
    w.byte_index = OFFSET_W'($urandom);
    w.data_in    = BYTE_W'($urandom);
    for (int s = 0; s < ENTRIES; s++) begin
      if (live_mask[s]) begin
        live_q.push_back(s);
        if (written_at[s].size() != 0) readable_q.push_back(s);
      end else begin
        free_q.push_back(s);
      end
    end
    // swing between filling and draining, lingering at full and empty
    if (fill_mode && free_q.size() == 0 && $urandom_range(3) == 0) fill_mode = 1'b0;
    else if (!fill_mode && live_q.size() == 0 && $urandom_range(3) == 0) fill_mode = 1'b1;

    roll = $urandom_range(99);
    if (roll < 38) w.action = ((roll < 30) == fill_mode) ? ACT_INSERT : ACT_EVICT;
    else if (roll < 62) w.action = ACT_LOOKUP;
    else if (roll < 80) w.action = ACT_WRITE;
    else if (roll < 97) w.action = ACT_READ;
    else w.action = ACT_ACTION_SPARE();

    case (w.action)
      ACT_LOOKUP, ACT_INSERT: begin
        if ($urandom_range(99) < 80) begin
          k          = $urandom_range(POOL-1);
          w.node_id  = pool_node[k];
          w.block_id = pool_block[k];
        end
      end
      ACT_READ: begin
        // read bytes written since the entry was filled, else a free slot
        if (readable_q.size() != 0 && (free_q.size() == 0 || $urandom_range(3) != 0)) begin
          k            = readable_q[$urandom_range(readable_q.size()-1)];
          w.slot       = SLOT_W'(k);
          w.byte_index = written_at[k][$urandom_range(written_at[k].size()-1)];
        end else if (free_q.size() != 0) begin
          w.slot = SLOT_W'(free_q[$urandom_range(free_q.size()-1)]);
        end else begin
          w.action = ACT_WRITE;
        end
      end
      default: ;
    endcase
    if (w.action == ACT_WRITE && live_q.size() != 0 && $urandom_range(99) < 80)
      w.slot = SLOT_W'(live_q[$urandom_range(live_q.size()-1)]);

    // refresh the key pool now and then
    if ($urandom_range(49) == 0) begin
      k             = $urandom_range(POOL-1);
      pool_node[k]  = {$urandom, $urandom};
      pool_block[k] = {$urandom, $urandom};
    end
    return w;
  endfunction

  // Stimulus and verdict
  initial begin
    req.valid   = 1'b0;
    req.payload = '0;
    for (int a = 0; a < 8; a++) tally[a] = 0;
    for (int p = 0; p < POOL; p++) begin
      pool_node[p]  = {$urandom, $urandom};
      pool_block[p] = {$urandom, $urandom};
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    settle();

    // empty cache: miss, failed evict, free-slot accesses
    issue(make(ACT_LOOKUP, KEY_ONES, KEY_ONES, 0, 0, 0));
    issue(make(ACT_EVICT, '0, '0, 31, 1023, 255));
    issue(make(ACT_READ, '0, '0, 31, 1023, 0));
    issue(make(ACT_WRITE, '0, '0, 0, 0, 255));
    // extreme keys, then a duplicate insert
    issue(make(ACT_INSERT, '0, '0, 0, 0, 0));
    issue(make(ACT_INSERT, KEY_ONES, KEY_ONES, 31, 1023, 255));
    issue(make(ACT_INSERT, KEY_ONES, KEY_ONES, 0, 0, 0));
    // the duplicate resolves to its lowest entry; half a key misses
    issue(make(ACT_LOOKUP, KEY_ONES, KEY_ONES, 0, 0, 0));
    issue(make(ACT_LOOKUP, '0, '0, 31, 1023, 255));
    issue(make(ACT_LOOKUP, KEY_ONES, '0, 0, 0, 0));
    // byte extremes on live entries
    issue(make(ACT_WRITE, '0, '0, 1, 0, 255));
    issue(make(ACT_WRITE, '0, '0, 1, 1023, 0));
    issue(make(ACT_WRITE, '0, '0, 2, 512, 165));
    issue(make(ACT_READ, '0, '0, 1, 0, 0));
    issue(make(ACT_READ, '0, '0, 1, 1023, 255));
    issue(make(ACT_READ, '0, '0, 2, 512, 0));
    // unused action codes
    for (int c = ACT_SPARE_LO; c <= ACT_SPARE_HI; c++)
      issue(make(ACTION_W'(c), KEY_ONES, KEY_ONES, 31, 1023, 255));
    // the oldest entry (slot 2) leaves; then an unwritten byte of live slot 0 is read
    issue(make(ACT_EVICT, '0, '0, 0, 0, 0));
    issue(make(ACT_READ, '0, '0, 0, 512, 0));
    drain();

    // random traffic under each pacing phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 64;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 64;
        end
        default: begin
          idle_pct  = 36;
          stall_pct = 36;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) issue(pick_request());
      drain();
    end

    repeat (ENTRIES + 8) @(posedge clk);
    $display("Run covered lookup %0d, insert %0d, evict %0d, byte write %0d, byte read %0d,",
             tally[ACT_LOOKUP], tally[ACT_INSERT], tally[ACT_EVICT], tally[ACT_WRITE],
             tally[ACT_READ]);
    $display("  spare %0d requests; %0d responses compared, %0d mismatches",
             tally[5] + tally[6] + tally[7], compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(8_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/lbc_pkg.sv
rtl/core/lbc_chan_if.sv
rtl/core/lbc_ctrl.sv
rtl/core/lbc_datapath.sv
rtl/core/lru_block_cache_unit.sv
tb/lru_block_cache_unit_checker.sv
tb/lru_block_cache_unit_test.sv
